>>> rtl/core/tpg_pkg.sv
// Shared types and constants for the topology path generator.
// No dependencies; used by every module under rtl/core.
package tpg_pkg;

    // Topology mode codes
    localparam logic [2:0] MODE_BUS  = 3'd0;
    localparam logic [2:0] MODE_XBAR = 3'd1;
    localparam logic [2:0] MODE_MESH = 3'd2;
    localparam logic [2:0] MODE_RING = 3'd3;
    localparam logic [2:0] MODE_TREE = 3'd4;

    // Register indexes (byte address = 4 * index)
    localparam int          ADDR_W   = 4;
    localparam logic [1:0]  REG_MODE = 2'd0;
    localparam logic [1:0]  REG_GRID = 2'd1;
    localparam logic [1:0]  REG_RING = 2'd2;

    // Reset values and limits
    localparam logic [2:0] MODE_RESET   = MODE_BUS;
    localparam logic [4:0] DEFAULT_GRID = 5'd4;
    localparam logic [4:0] GRID_LIMIT   = 5'd16;
    localparam logic [6:0] RING_RESET   = 7'd0;
    localparam int         MAX_ITEMS    = 33;

    // Shared arithmetic unit opcodes
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [2:0] topology_mode;
        logic [4:0] grid_width;
        logic [6:0] ring_size;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic [8:0] a;
        logic [8:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [8:0] sum;
        logic       neg;
    } alu_rsp_t;

    typedef struct packed {
        logic [5:0] path_node;
        logic [5:0] hop_total;
        logic       is_last;
        logic       is_empty;
    } out_item_t;

endpackage

>>> rtl/core/tpg_cfg.sv
// Configuration register file behind an APB-style port.
// Depends on tpg_pkg.
module tpg_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpg_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output tpg_pkg::cfg_t                 cfg
);

    logic [2:0] mode_reg;
    logic [4:0] grid_reg;
    logic [6:0] ring_reg;
    logic       wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tpg_pkg::MODE_RESET;
            grid_reg <= tpg_pkg::DEFAULT_GRID;
            ring_reg <= tpg_pkg::RING_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                tpg_pkg::REG_MODE: mode_reg <= pwdata[2:0];
                tpg_pkg::REG_GRID: grid_reg <= pwdata[4:0];
                tpg_pkg::REG_RING: ring_reg <= pwdata[6:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            tpg_pkg::REG_MODE: prdata = {29'd0, mode_reg};
            tpg_pkg::REG_GRID: prdata = {27'd0, grid_reg};
            tpg_pkg::REG_RING: prdata = {25'd0, ring_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.topology_mode = mode_reg;
    assign cfg.grid_width    = grid_reg;
    assign cfg.ring_size     = ring_reg;

endmodule

>>> rtl/core/tpg_alu.sv
// Shared 9-bit add/subtract unit; sign of the result flags a borrow.
// Depends on tpg_pkg.
module tpg_alu
(
    input  tpg_pkg::alu_req_t req,
    output tpg_pkg::alu_rsp_t rsp
);

    logic [8:0] sum;

    always_comb
    begin
        unique case (req.op)
            tpg_pkg::ALU_ADD: sum = req.a + req.b;
            tpg_pkg::ALU_SUB: sum = req.a - req.b;
            default:          sum = req.a + req.b;
        endcase
    end

    assign rsp.sum = sum;
    assign rsp.neg = sum[8];

endmodule

>>> rtl/core/tpg_seq.sv
// Route sequencer: mesh coordinate division, ring direction choice and node walk,
// all through the shared add/subtract unit. Depends on tpg_pkg.
module tpg_seq
#(
    parameter int MAX_NODES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpg_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    input  logic [7:0]           in_source,
    input  logic [7:0]           in_dest,
    output logic                 idle,
    input  logic                 slot_free,
    output logic                 emit,
    output tpg_pkg::out_item_t   item,
    output tpg_pkg::alu_req_t    alu_req,
    input  tpg_pkg::alu_rsp_t    alu_rsp
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EMPTY = 4'd1;
    localparam logic [3:0] S_DIVS  = 4'd2;
    localparam logic [3:0] S_DIVD  = 4'd3;
    localparam logic [3:0] S_XA    = 4'd4;
    localparam logic [3:0] S_XB    = 4'd5;
    localparam logic [3:0] S_YA    = 4'd6;
    localparam logic [3:0] S_YB    = 4'd7;
    localparam logic [3:0] S_HOPS  = 4'd8;
    localparam logic [3:0] S_RA    = 4'd9;
    localparam logic [3:0] S_RB    = 4'd10;
    localparam logic [3:0] S_RC    = 4'd11;
    localparam logic [3:0] S_RD    = 4'd12;
    localparam logic [3:0] S_WALK  = 4'd13;

    localparam logic [1:0] K_DIRECT = 2'd0;
    localparam logic [1:0] K_MESH   = 2'd1;
    localparam logic [1:0] K_RING   = 2'd2;

    localparam logic [5:0] LAST_CNT = 6'(tpg_pkg::MAX_ITEMS - 1);

    logic [3:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] src_reg, src_next;
    logic [7:0] dst_reg, dst_next;
    logic [7:0] node_reg, node_next;
    logic [7:0] rem_reg, rem_next;
    logic [4:0] quo_reg, quo_next;
    logic [3:0] cx_reg, cx_next;
    logic [3:0] cy_reg, cy_next;
    logic [3:0] tx_reg, tx_next;
    logic [3:0] ty_reg, ty_next;
    logic [3:0] xs_reg, xs_next;
    logic [3:0] ys_reg, ys_next;
    logic       xup_reg, xup_next;
    logic       yup_reg, yup_next;
    logic       rup_reg, rup_next;
    logic [6:0] fwd_reg, fwd_next;
    logic [6:0] steps_reg, steps_next;
    logic [6:0] hop_reg, hop_next;
    logic [5:0] cnt_reg, cnt_next;

    logic [4:0] w_eff;
    logic [9:0] w_sq;
    logic [6:0] n_eff;
    logic       in_bad;
    logic       mesh_off;
    logic       ring_off;
    logic       remaining;
    logic       last;
    logic [7:0] ring_next;

    // effective grid width and ring length
    always_comb
    begin
        if (cfg.grid_width == 5'd0)
            w_eff = tpg_pkg::DEFAULT_GRID;
        else if (cfg.grid_width > tpg_pkg::GRID_LIMIT)
            w_eff = tpg_pkg::GRID_LIMIT;
        else
            w_eff = cfg.grid_width;
    end

    assign w_sq  = {5'd0, w_eff} * {5'd0, w_eff};
    assign n_eff = (int'(cfg.ring_size) > MAX_NODES) ? 7'(MAX_NODES) : cfg.ring_size;

    assign in_bad   = (int'(in_source) >= MAX_NODES) || (int'(in_dest) >= MAX_NODES);
    assign mesh_off = ({2'b00, in_source} >= w_sq) || ({2'b00, in_dest} >= w_sq);
    assign ring_off = (in_source >= {1'b0, n_eff}) || (in_dest >= {1'b0, n_eff});

    assign remaining = (kind_reg == K_MESH) ? ((xs_reg != 4'd0) || (ys_reg != 4'd0))
                                            : (steps_reg != 7'd0);
    assign last      = !remaining || (cnt_reg == LAST_CNT);

    assign idle = (state_reg == S_IDLE);
    assign emit = ((state_reg == S_WALK) || (state_reg == S_EMPTY)) && slot_free;

    // result word
    always_comb
    begin
        if (state_reg == S_EMPTY)
        begin
            item.path_node = 6'd0;
            item.hop_total = 6'd0;
            item.is_last   = 1'b1;
            item.is_empty  = 1'b1;
        end
        else
        begin
            item.path_node = node_reg[5:0];
            item.hop_total = last ? hop_reg[5:0] : 6'd0;
            item.is_last   = last;
            item.is_empty  = 1'b0;
        end
    end

    // operand select for the shared unit
    always_comb
    begin
        alu_req.op = tpg_pkg::ALU_SUB;
        alu_req.a  = {1'b0, rem_reg};
        alu_req.b  = {4'd0, w_eff};
        case (state_reg)
            S_XA:
            begin
                alu_req.a = {5'd0, tx_reg};
                alu_req.b = {5'd0, cx_reg};
            end
            S_XB:
            begin
                alu_req.a = {5'd0, cx_reg};
                alu_req.b = {5'd0, tx_reg};
            end
            S_YA:
            begin
                alu_req.a = {5'd0, ty_reg};
                alu_req.b = {5'd0, cy_reg};
            end
            S_YB:
            begin
                alu_req.a = {5'd0, cy_reg};
                alu_req.b = {5'd0, ty_reg};
            end
            S_HOPS:
            begin
                alu_req.op = tpg_pkg::ALU_ADD;
                alu_req.a  = {5'd0, xs_reg};
                alu_req.b  = {5'd0, ys_reg};
            end
            S_RA:
            begin
                alu_req.a = {1'b0, dst_reg};
                alu_req.b = {1'b0, src_reg};
            end
            S_RB:
            begin
                alu_req.op = tpg_pkg::ALU_ADD;
                alu_req.a  = {1'b0, rem_reg};
                alu_req.b  = {2'b00, n_eff};
            end
            S_RC:
            begin
                // forward wins when 2*fwd <= n
                alu_req.a = {2'b00, n_eff};
                alu_req.b = {1'b0, fwd_reg, 1'b0};
            end
            S_RD:
            begin
                alu_req.a = {2'b00, n_eff};
                alu_req.b = {2'b00, fwd_reg};
            end
            S_WALK:
            begin
                alu_req.b = 9'd1;
                case (kind_reg)
                    K_MESH:
                    begin
                        alu_req.a = {1'b0, node_reg};
                        if (xs_reg != 4'd0)
                            alu_req.op = xup_reg ? tpg_pkg::ALU_ADD : tpg_pkg::ALU_SUB;
                        else
                        begin
                            alu_req.op = yup_reg ? tpg_pkg::ALU_ADD : tpg_pkg::ALU_SUB;
                            alu_req.b  = {4'd0, w_eff};
                        end
                    end
                    K_RING:
                    begin
                        if (rup_reg)
                        begin
                            alu_req.op = tpg_pkg::ALU_ADD;
                            alu_req.a  = {1'b0, node_reg};
                        end
                        else
                            alu_req.a = (node_reg == 8'd0) ? {2'b00, n_eff}
                                                           : {1'b0, node_reg};
                    end
                    default:
                    begin
                        alu_req.op = tpg_pkg::ALU_ADD;
                        alu_req.a  = {1'b0, dst_reg};
                        alu_req.b  = 9'd0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // forward ring step wraps at the ring length
    assign ring_next = (alu_rsp.sum[7:0] == {1'b0, n_eff}) ? 8'd0 : alu_rsp.sum[7:0];

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        node_next  = node_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        xs_next    = xs_reg;
        ys_next    = ys_reg;
        xup_next   = xup_reg;
        yup_next   = yup_reg;
        rup_next   = rup_reg;
        fwd_next   = fwd_reg;
        steps_next = steps_reg;
        hop_next   = hop_reg;
        cnt_next   = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    src_next   = in_source;
                    dst_next   = in_dest;
                    node_next  = in_source;
                    cnt_next   = 6'd0;
                    kind_next  = K_DIRECT;
                    steps_next = 7'd0;
                    hop_next   = 7'd1;
                    if (in_bad)
                        state_next = S_EMPTY;
                    else
                    begin
                        unique case (cfg.topology_mode) inside
                            tpg_pkg::MODE_BUS, tpg_pkg::MODE_XBAR, tpg_pkg::MODE_TREE:
                            begin
                                steps_next = {6'd0, (in_source != in_dest)};
                                state_next = S_WALK;
                            end
                            tpg_pkg::MODE_MESH:
                            begin
                                if (mesh_off)
                                    state_next = S_WALK;
                                else
                                begin
                                    kind_next  = K_MESH;
                                    rem_next   = in_source;
                                    quo_next   = 5'd0;
                                    state_next = S_DIVS;
                                end
                            end
                            tpg_pkg::MODE_RING:
                            begin
                                hop_next = 7'd0;
                                if (n_eff == 7'd0)
                                    state_next = S_EMPTY;
                                else if (ring_off)
                                    state_next = S_WALK;
                                else
                                begin
                                    kind_next  = K_RING;
                                    state_next = S_RA;
                                end
                            end
                            default: state_next = S_EMPTY;
                        endcase
                    end
                end
            end
            S_EMPTY:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            S_DIVS, S_DIVD:
            begin
                // repeated subtraction of the grid width
                if (!alu_rsp.neg)
                begin
                    rem_next = alu_rsp.sum[7:0];
                    quo_next = quo_reg + 5'd1;
                end
                else if (state_reg == S_DIVS)
                begin
                    cx_next    = rem_reg[3:0];
                    cy_next    = quo_reg[3:0];
                    rem_next   = dst_reg;
                    quo_next   = 5'd0;
                    state_next = S_DIVD;
                end
                else
                begin
                    tx_next    = rem_reg[3:0];
                    ty_next    = quo_reg[3:0];
                    state_next = S_XA;
                end
            end
            S_XA:
            begin
                xs_next  = alu_rsp.sum[3:0];
                xup_next = 1'b1;
                state_next = alu_rsp.neg ? S_XB : S_YA;
            end
            S_XB:
            begin
                xs_next    = alu_rsp.sum[3:0];
                xup_next   = 1'b0;
                state_next = S_YA;
            end
            S_YA:
            begin
                ys_next  = alu_rsp.sum[3:0];
                yup_next = 1'b1;
                state_next = alu_rsp.neg ? S_YB : S_HOPS;
            end
            S_YB:
            begin
                ys_next    = alu_rsp.sum[3:0];
                yup_next   = 1'b0;
                state_next = S_HOPS;
            end
            S_HOPS:
            begin
                hop_next   = alu_rsp.sum[6:0];
                state_next = S_WALK;
            end
            S_RA:
            begin
                if (!alu_rsp.neg)
                begin
                    fwd_next   = alu_rsp.sum[6:0];
                    state_next = S_RC;
                end
                else
                begin
                    rem_next   = alu_rsp.sum[7:0];
                    state_next = S_RB;
                end
            end
            S_RB:
            begin
                fwd_next   = alu_rsp.sum[6:0];
                state_next = S_RC;
            end
            S_RC:
            begin
                if (!alu_rsp.neg)
                begin
                    steps_next = fwd_reg;
                    hop_next   = fwd_reg;
                    rup_next   = 1'b1;
                    state_next = S_WALK;
                end
                else
                    state_next = S_RD;
            end
            S_RD:
            begin
                steps_next = alu_rsp.sum[6:0];
                hop_next   = alu_rsp.sum[6:0];
                rup_next   = 1'b0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (slot_free)
                begin
                    if (last)
                        state_next = S_IDLE;
                    else
                    begin
                        cnt_next = cnt_reg + 6'd1;
                        if (kind_reg == K_MESH)
                        begin
                            node_next = alu_rsp.sum[7:0];
                            if (xs_reg != 4'd0)
                                xs_next = xs_reg - 4'd1;
                            else
                                ys_next = ys_reg - 4'd1;
                        end
                        else
                        begin
                            steps_next = steps_reg - 7'd1;
                            if ((kind_reg == K_RING) && rup_reg)
                                node_next = ring_next;
                            else
                                node_next = alu_rsp.sum[7:0];
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        node_reg  <= node_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        xs_reg    <= xs_next;
        ys_reg    <= ys_next;
        xup_reg   <= xup_next;
        yup_reg   <= yup_next;
        rup_reg   <= rup_next;
        fwd_reg   <= fwd_next;
        steps_reg <= steps_next;
        hop_reg   <= hop_next;
        cnt_reg   <= cnt_next;
    end

endmodule

>>> rtl/core/topology_path_generator_core.sv
// Top level of the topology path generator: config port, sequencer, shared
// add/subtract unit and output register. Depends on tpg_pkg, tpg_cfg, tpg_alu, tpg_seq.

// Takes one (source, destination) request word and returns the route one node
// per output word, source first; the last word has tlast set and carries the
// hop count. Bus, crossbar and tree give source then destination (source alone
// if equal) with one hop. Mesh routes X then Y on a grid grid_width wide; a node
// off the grid gives source alone, one hop. Ring goes the shorter way, ties
// forward; a node past the ring length gives source alone, zero hops. An out of
// range node, an unknown mode or an empty ring give a single word with tuser set.
// Flow: tready is high only while idle; once a request is taken it stays low
// until the last word of the route has entered the output register. Route setup
// runs on one shared 9-bit add/subtract unit: none for bus/crossbar/tree; ring
// takes differences to choose the direction; mesh divides source and destination
// by the grid width by repeated subtraction, then adds the X and Y distances.
// After setup one node leaves per cycle while the output side takes it, at most
// 33 words per route. A single output register sits on the master side, so a new
// request is taken while the final word still waits for tready.
module topology_path_generator_core
#(
    parameter int MAX_NODES = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpg_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [7:0] source_node, [15:8] dest_node
    // route stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [5:0] path_node, [11:6] hop_total
    output logic                          m_axis_tlast,   // is_last
    output logic                          m_axis_tuser    // is_empty
);

    tpg_pkg::cfg_t      cfg;
    tpg_pkg::alu_req_t  alu_req;
    tpg_pkg::alu_rsp_t  alu_rsp;
    tpg_pkg::out_item_t seq_item;
    logic               seq_idle;
    logic               seq_emit;
    logic               slot_free;

    // output register
    logic               out_valid_reg, out_valid_next;
    tpg_pkg::out_item_t out_item_reg;

    tpg_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpg_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    tpg_seq #(.MAX_NODES(MAX_NODES)) u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_source (s_axis_tdata[7:0]),
        .in_dest   (s_axis_tdata[15:8]),
        .idle      (seq_idle),
        .slot_free (slot_free),
        .emit      (seq_emit),
        .item      (seq_item),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp)
    );

    // input is taken only while the sequencer sits idle
    assign s_axis_tready = seq_idle;

    // output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        if (seq_emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (seq_emit)
            out_item_reg <= seq_item;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_item_reg.hop_total, out_item_reg.path_node};
    assign m_axis_tlast  = out_item_reg.is_last;
    assign m_axis_tuser  = out_item_reg.is_empty;

    // an empty-route word is always the final, all-zero word
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 16'd0))
        else $error("empty route word malformed");

    // hop count only rides on the last word of a route
    a_hop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[11:6] == 6'd0))
        else $error("hop count on a non-final word");

    // a request is never followed by another in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one still routing");

endmodule
